FILE: rtl/core/cra_pkg.sv
package cra_pkg;

   localparam int CELLS_DEFAULT = 1024;

   localparam int START_W    = 10;
   localparam int LEN_W      = 11;
   localparam int STATUS_W   = 2;
   localparam int STRATEGY_W = 2;

   localparam logic [STRATEGY_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [STRATEGY_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [STRATEGY_W-1:0] FIT_WORST = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_NO_ROOM  = 2'd1,
      STATUS_ZERO_LEN = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_DECIDE,
      ST_WALK,
      ST_RESPOND
   } ctl_state_type;

   typedef struct packed {
      logic       capture;
      logic       clear_step;
      logic       scan_init;
      logic       scan_run;
      logic       walk_init;
      logic       walk_step;
      logic       set_code;
      status_type code;
      logic       push;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic op_release;
      logic zero_len;
      logic bad_strategy;
      logic scan_done;
      logic found;
      logic walk_done;
      logic slot_free;
   } sts_type;

endpackage

FILE: rtl/core/contiguous_run_allocator.sv
// Allocate: a serial scan of the whole occupancy map (one cell per cycle through a
// registered RAM read) is followed by the marking walk (one cell per cycle).
// Release: the marking walk alone, which stops early at the end of the store.
// Zero-length allocation: a reply with no scan and no walk.
// One item is worked at a time; the result register frees the input side early.
// After reset a clearing pass marks every cell free before any transfer.
module contiguous_run_allocator #(
   parameter int CELLS = cra_pkg::CELLS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic [cra_pkg::START_W-1:0]       req_run_start,
   input  logic [cra_pkg::LEN_W-1:0]         req_run_length,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cra_pkg::STATUS_W-1:0]      rsp_status,
   output logic [cra_pkg::START_W-1:0]       rsp_placed_start,
   output logic [cra_pkg::LEN_W-1:0]         rsp_chosen_run_size,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cra_pkg::STRATEGY_W-1:0]    csr_fit_strategy
);

   cra_pkg::cmd_type cmd;
   cra_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   cra_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   cra_dp #(
      .CELLS (CELLS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_operation       (req_operation),
      .req_run_start       (req_run_start),
      .req_run_length      (req_run_length),
      .csr_valid           (csr_valid),
      .csr_fit_strategy    (csr_fit_strategy),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_placed_start    (rsp_placed_start),
      .rsp_chosen_run_size (rsp_chosen_run_size)
   );

endmodule

FILE: rtl/core/cra_ram.sv
module cra_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cra_ctl.sv
module cra_ctl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output cra_pkg::cmd_type cmd,
   input  cra_pkg::sts_type sts
);

   cra_pkg::ctl_state_type state_ff;
   cra_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cra_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.code  = cra_pkg::STATUS_DONE;
      case (state_ff)
         cra_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = cra_pkg::ST_IDLE;
            end
         end
         cra_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = cra_pkg::ST_DISPATCH;
            end
         end
         cra_pkg::ST_DISPATCH: begin
            if (sts.op_release) begin
               cmd.walk_init = 1'b1;
               state_in      = cra_pkg::ST_WALK;
            end else if (sts.zero_len) begin
               cmd.set_code = 1'b1;
               cmd.code     = cra_pkg::STATUS_ZERO_LEN;
               state_in     = cra_pkg::ST_RESPOND;
            end else if (sts.bad_strategy) begin
               cmd.set_code = 1'b1;
               cmd.code     = cra_pkg::STATUS_NO_ROOM;
               state_in     = cra_pkg::ST_RESPOND;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = cra_pkg::ST_SCAN;
            end
         end
         cra_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = cra_pkg::ST_DECIDE;
            end
         end
         cra_pkg::ST_DECIDE: begin
            if (sts.found) begin
               cmd.walk_init = 1'b1;
               state_in      = cra_pkg::ST_WALK;
            end else begin
               cmd.set_code = 1'b1;
               cmd.code     = cra_pkg::STATUS_NO_ROOM;
               state_in     = cra_pkg::ST_RESPOND;
            end
         end
         cra_pkg::ST_WALK: begin
            if (sts.walk_done) begin
               cmd.set_code = 1'b1;
               cmd.code     = cra_pkg::STATUS_DONE;
               state_in     = cra_pkg::ST_RESPOND;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         cra_pkg::ST_RESPOND: begin
            if (sts.slot_free) begin
               cmd.push = 1'b1;
               state_in = cra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cra_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/cra_dp.sv
module cra_dp #(
   parameter int CELLS = cra_pkg::CELLS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cra_pkg::cmd_type                  cmd,
   output cra_pkg::sts_type                  sts,
   input  logic                              req_operation,
   input  logic [cra_pkg::START_W-1:0]       req_run_start,
   input  logic [cra_pkg::LEN_W-1:0]         req_run_length,
   input  logic                              csr_valid,
   input  logic [cra_pkg::STRATEGY_W-1:0]    csr_fit_strategy,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cra_pkg::STATUS_W-1:0]      rsp_status,
   output logic [cra_pkg::START_W-1:0]       rsp_placed_start,
   output logic [cra_pkg::LEN_W-1:0]         rsp_chosen_run_size
);

   localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int PW = ((AW > cra_pkg::START_W) ? AW : cra_pkg::START_W) + 1;
   localparam int LW = $clog2(CELLS + 1);
   localparam int CW = (LW > cra_pkg::LEN_W) ? LW : cra_pkg::LEN_W;

   logic                              req_op_ff;
   logic [cra_pkg::START_W-1:0]       req_start_ff;
   logic [cra_pkg::LEN_W-1:0]         req_len_ff;
   logic [cra_pkg::STRATEGY_W-1:0]    strategy_ff;
   logic [PW-1:0]                     ptr_ff, ptr_in;
   logic [cra_pkg::LEN_W-1:0]         rem_ff;
   logic                              rd_vld_ff;
   logic [AW-1:0]                     rd_idx_ff;
   logic [LW-1:0]                     run_len_ff;
   logic [AW-1:0]                     run_start_ff;
   logic                              found_ff, found_in;
   logic [AW-1:0]                     pick_start_ff;
   logic [LW-1:0]                     pick_len_ff;
   cra_pkg::status_type               code_ff;
   logic                              rsp_valid_ff;
   cra_pkg::status_type               rsp_status_ff;
   logic [cra_pkg::START_W-1:0]       rsp_start_ff;
   logic [cra_pkg::LEN_W-1:0]         rsp_size_ff;

   logic          ptr_in_store;
   logic          rd_en;
   logic          mem_we;
   logic          mem_wd;
   logic [0:0]    mem_rd_data;
   logic          cell_free;
   logic          cell_last;
   logic [LW-1:0] run_len_inc;
   logic [LW-1:0] closed_len;
   logic [AW-1:0] closed_start;
   logic          run_close;
   logic          run_fits;
   logic          run_take;

   assign ptr_in_store = (ptr_ff < PW'(CELLS));
   assign rd_en        = cmd.scan_run && ptr_in_store;
   assign mem_we       = cmd.clear_step || cmd.walk_step;
   assign mem_wd       = cmd.walk_step && !req_op_ff;

   cra_ram #(
      .WIDTH (1),
      .DEPTH (CELLS)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (ptr_ff[AW-1:0]),
      .wr_data (mem_wd),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   // A free run closes on the first used cell after it or on the last cell of the store.
   assign cell_free    = ~mem_rd_data[0];
   assign cell_last    = (rd_idx_ff == AW'(CELLS - 1));
   assign run_len_inc  = run_len_ff + LW'(1);
   assign closed_len   = cell_free ? run_len_inc : run_len_ff;
   assign closed_start = (cell_free && run_len_ff == '0) ? rd_idx_ff : run_start_ff;
   assign run_close    = rd_vld_ff && ((!cell_free && run_len_ff != '0) ||
                                       (cell_free && cell_last));
   assign run_fits     = (CW'(closed_len) >= CW'(req_len_ff));
   assign run_take     = run_close && run_fits &&
                         (!found_ff ||
                          (strategy_ff == cra_pkg::FIT_BEST  && closed_len < pick_len_ff) ||
                          (strategy_ff == cra_pkg::FIT_WORST && closed_len > pick_len_ff));

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.clear_step || cmd.walk_step || rd_en) begin
         ptr_in = ptr_ff + PW'(1);
      end else if (cmd.scan_init) begin
         ptr_in = '0;
      end else if (cmd.walk_init) begin
         ptr_in = req_op_ff ? PW'(req_start_ff) : PW'(pick_start_ff);
      end
   end

   always_comb begin
      found_in = found_ff;
      if (cmd.capture) begin
         found_in = 1'b0;
      end else if (run_take) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff  <= cra_pkg::FIT_FIRST;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            strategy_ff <= csr_fit_strategy;
         end
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= rd_en;
         found_ff     <= found_in;
         rsp_valid_ff <= cmd.push || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_op_ff    <= req_operation;
         req_start_ff <= req_run_start;
         req_len_ff   <= req_run_length;
      end
      if (cmd.walk_init) begin
         rem_ff <= req_len_ff;
      end else if (cmd.walk_step) begin
         rem_ff <= rem_ff - cra_pkg::LEN_W'(1);
      end
      if (rd_en) begin
         rd_idx_ff <= ptr_ff[AW-1:0];
      end
      if (cmd.scan_init) begin
         run_len_ff <= '0;
      end else if (rd_vld_ff) begin
         run_len_ff   <= cell_free ? run_len_inc : '0;
         run_start_ff <= closed_start;
      end
      if (run_take) begin
         pick_start_ff <= closed_start;
         pick_len_ff   <= closed_len;
      end
      if (cmd.set_code) begin
         code_ff <= cmd.code;
      end
      if (cmd.push) begin
         rsp_status_ff <= code_ff;
         if (code_ff == cra_pkg::STATUS_DONE && req_op_ff) begin
            rsp_start_ff <= req_start_ff;
            rsp_size_ff  <= '0;
         end else if (code_ff == cra_pkg::STATUS_DONE) begin
            rsp_start_ff <= cra_pkg::START_W'(pick_start_ff);
            rsp_size_ff  <= cra_pkg::LEN_W'(pick_len_ff);
         end else begin
            rsp_start_ff <= '0;
            rsp_size_ff  <= '0;
         end
      end
   end

   always_comb begin
      sts              = '0;
      sts.clear_last   = (ptr_ff == PW'(CELLS - 1));
      sts.op_release   = req_op_ff;
      sts.zero_len     = (req_len_ff == '0);
      sts.bad_strategy = (strategy_ff > cra_pkg::FIT_WORST);
      sts.scan_done    = rd_vld_ff && cell_last;
      sts.found        = found_ff;
      sts.walk_done    = (rem_ff == '0) || !ptr_in_store;
      sts.slot_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_placed_start    = rsp_start_ff;
   assign rsp_chosen_run_size = rsp_size_ff;

   a_push_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (!rsp_valid_ff || rsp_ready))
      else $error("Result loaded while the previous transfer is still pending.");

   a_write_inside_store: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ptr_in_store)
      else $error("Map write outside the store.");

   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (CW'(pick_len_ff) >= CW'(req_len_ff)))
      else $error("Chosen free run is shorter than the request.");

   a_read_inside_store: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(ptr_in_store))
      else $error("Scan read issued outside the store.");

endmodule

FILE: bench/alloc_bench_pkg.sv
package alloc_bench_pkg;

   typedef enum logic {
      OP_ALLOCATE = 1'b0,
      OP_RELEASE  = 1'b1
   } op_type;

   // Strategy code with no placement rule behind it; every allocation of nonzero length misses.
   localparam logic [cra_pkg::STRATEGY_W-1:0] FIT_UNUSED = 2'd3;

endpackage

FILE: bench/run_allocator_checker.sv
module run_allocator_checker
   import cra_pkg::*;
   import alloc_bench_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_operation,
   input  logic [START_W-1:0]    req_run_start,
   input  logic [LEN_W-1:0]      req_run_length,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic [START_W-1:0]    rsp_placed_start,
   input  logic [LEN_W-1:0]      rsp_chosen_run_size,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [STRATEGY_W-1:0] csr_fit_strategy,
   output int                    mismatches,
   output int                    awaited
);

   localparam int CELLS = CELLS_DEFAULT;

   typedef struct {
      status_type          status;
      logic [START_W-1:0]  start;
      logic [LEN_W-1:0]    size;
   } reply_type;

   logic                  cell_taken [CELLS];
   logic [STRATEGY_W-1:0] fit_rule;
   reply_type             expected_replies [$];

   initial begin
      mismatches = 0;
      awaited = 0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Applies one item to the occupancy map and returns the reply it must produce.
   function automatic reply_type place_or_release(input op_type op,
                                                  input logic [START_W-1:0] first,
                                                  input logic [LEN_W-1:0] count);
      reply_type r;
      int pos;
      int stop;
      int span;
      int pick_at;
      int pick_span;
      bit found;
      bit take;
      r.status = STATUS_DONE;
      r.start = '0;
      r.size = '0;
      if (op == OP_RELEASE) begin
         for (int k = 0; k < count && first + k < CELLS; k++) begin
            cell_taken[first + k] = 1'b0;
         end
         r.start = first;
         return r;
      end
      if (count == 0) begin
         r.status = STATUS_ZERO_LEN;
         return r;
      end
      if (fit_rule > FIT_WORST) begin
         r.status = STATUS_NO_ROOM;
         return r;
      end
      found = 1'b0;
      pick_at = 0;
      pick_span = 0;
      pos = 0;
      while (pos < CELLS) begin
         if (cell_taken[pos]) begin
            pos++;
            continue;
         end
         stop = pos;
         while (stop < CELLS && !cell_taken[stop]) stop++;
         span = stop - pos;
         take = 1'b0;
         if (span >= count) begin
            if (!found) take = 1'b1;
            else if (fit_rule == FIT_BEST && span < pick_span) take = 1'b1;
            else if (fit_rule == FIT_WORST && span > pick_span) take = 1'b1;
         end
         if (take) begin
            found = 1'b1;
            pick_at = pos;
            pick_span = span;
            if (fit_rule == FIT_FIRST) break;
         end
         pos = stop;
      end
      if (!found) begin
         r.status = STATUS_NO_ROOM;
         return r;
      end
      for (int k = 0; k < count; k++) begin
         cell_taken[pick_at + k] = 1'b1;
      end
      r.start = START_W'(pick_at);
      r.size = LEN_W'(pick_span);
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         foreach (cell_taken[c]) cell_taken[c] = 1'b0;
         fit_rule = FIT_FIRST;
         expected_replies.delete();
         awaited <= 0;
      end else begin
         if (csr_valid && csr_ready) fit_rule = csr_fit_strategy;
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("reply status %0d with no transfer awaiting one",
                                         rsp_status));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                            rsp_status, want.status));
               if (rsp_placed_start !== want.start)
                  report_mismatch($sformatf("placed start %0d, predicted %0d",
                                            rsp_placed_start, want.start));
               if (rsp_chosen_run_size !== want.size)
                  report_mismatch($sformatf("chosen run size %0d, predicted %0d",
                                            rsp_chosen_run_size, want.size));
            end
         end
         if (req_valid && req_ready)
            expected_replies.push_back(place_or_release(op_type'(req_operation),
                                                        req_run_start, req_run_length));
         awaited <= expected_replies.size();
      end
   end

endmodule

FILE: bench/tb_top.sv
module tb_top;
   import cra_pkg::*;
   import alloc_bench_pkg::*;

   localparam int HOLD_CYCLES   = 5000;
   localparam int SEGMENTS      = 8;
   localparam int SEGMENT_ITEMS = 34;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_operation = 1'b0;
   logic [START_W-1:0]    req_run_start = '0;
   logic [LEN_W-1:0]      req_run_length = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [START_W-1:0]    rsp_placed_start;
   logic [LEN_W-1:0]      rsp_chosen_run_size;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [STRATEGY_W-1:0] csr_fit_strategy = '0;

   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic pressure_go = 1'b0;
   logic rsp_hold = 1'b0;
   int   mismatches;
   int   awaited;

   logic [STRATEGY_W-1:0] seg_fit [SEGMENTS] = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_FIRST,
                                                 FIT_BEST, FIT_WORST, FIT_FIRST, FIT_WORST};
   int seg_idle [SEGMENTS]  = '{0, 55, 0, 30, 0, 55, 0, 30};
   int seg_stall [SEGMENTS] = '{0, 0, 55, 30, 0, 0, 55, 30};

   contiguous_run_allocator i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_run_start       (req_run_start),
      .req_run_length      (req_run_length),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_placed_start    (rsp_placed_start),
      .rsp_chosen_run_size (rsp_chosen_run_size),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_fit_strategy    (csr_fit_strategy)
   );

   run_allocator_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_run_start       (req_run_start),
      .req_run_length      (req_run_length),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_placed_start    (rsp_placed_start),
      .rsp_chosen_run_size (rsp_chosen_run_size),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_fit_strategy    (csr_fit_strategy),
      .mismatches          (mismatches),
      .awaited             (awaited)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || rsp_hold) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // The receiver holds off long enough for a result to park and the input side to stall.
   initial begin
      wait (pressure_go);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #40_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   task automatic send_item(input op_type op, input logic [START_W-1:0] first,
                            input logic [LEN_W-1:0] count);
      int gap;
      req_valid <= 1'b1;
      req_operation <= op;
      req_run_start <= first;
      req_run_length <= count;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(1, 1500) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_item();
      int                 pick;
      op_type             op;
      logic [START_W-1:0] first;
      logic [LEN_W-1:0]   count;
      pick = $urandom_range(99);
      first = START_W'($urandom_range(CELLS_DEFAULT - 1));
      if (pick < 47) begin
         op = OP_ALLOCATE;
         count = LEN_W'($urandom_range(1, 48));
      end else if (pick < 52) begin
         op = OP_ALLOCATE;
         count = LEN_W'($urandom_range(CELLS_DEFAULT));
      end else if (pick < 92) begin
         op = OP_RELEASE;
         count = LEN_W'($urandom_range(1, 48));
      end else if (pick < 97) begin
         op = OP_RELEASE;
         count = LEN_W'($urandom_range(CELLS_DEFAULT));
      end else begin
         op = op_type'($urandom_range(1));
         count = '0;
      end
      send_item(op, first, count);
   endtask

   task automatic write_strategy(input logic [STRATEGY_W-1:0] code);
      csr_valid <= 1'b1;
      csr_fit_strategy <= code;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited != 0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // First fit from the reset value: zero length, a full store, the end of the store.
      send_item(OP_ALLOCATE, 10'd517, 11'd0);
      send_item(OP_ALLOCATE, 10'd0, 11'd1024);
      send_item(OP_ALLOCATE, 10'd1023, 11'd1);
      send_item(OP_RELEASE, 10'd1023, 11'd1024);
      send_item(OP_RELEASE, 10'd0, 11'd0);
      send_item(OP_ALLOCATE, 10'd0, 11'd1);
      send_item(OP_RELEASE, 10'd0, 11'd1024);
      send_item(OP_ALLOCATE, 10'd682, 11'd10);
      send_item(OP_ALLOCATE, 10'd341, 11'd20);
      send_item(OP_ALLOCATE, 10'd0, 11'd5);
      send_item(OP_ALLOCATE, 10'd1023, 11'd100);
      send_item(OP_RELEASE, 10'd10, 11'd20);
      send_item(OP_RELEASE, 10'd0, 11'd5);

      settle();
      write_strategy(FIT_BEST);
      send_item(OP_ALLOCATE, 10'd0, 11'd3);
      send_item(OP_ALLOCATE, 10'd0, 11'd15);
      send_item(OP_ALLOCATE, 10'd0, 11'd889);
      send_item(OP_RELEASE, 10'd1000, 11'd24);
      send_item(OP_ALLOCATE, 10'd0, 11'd24);

      // Two free runs of equal length; worst fit must take the lower one.
      settle();
      write_strategy(FIT_WORST);
      send_item(OP_RELEASE, 10'd200, 11'd40);
      send_item(OP_RELEASE, 10'd600, 11'd40);
      send_item(OP_ALLOCATE, 10'd0, 11'd30);

      settle();
      write_strategy(FIT_UNUSED);
      send_item(OP_ALLOCATE, 10'd0, 11'd1);
      send_item(OP_ALLOCATE, 10'd0, 11'd0);
      send_item(OP_RELEASE, 10'd0, 11'd1024);

      for (int s = 0; s < SEGMENTS; s++) begin
         settle();
         write_strategy(seg_fit[s]);
         send_idle_pct <= seg_idle[s];
         stall_pct <= seg_stall[s];
         if (s == 2) pressure_go <= 1'b1;
         for (int n = 0; n < SEGMENT_ITEMS; n++) send_random_item();
      end

      settle();
      repeat (CELLS_DEFAULT + 64) @(posedge clock);
      if (mismatches == 0 && awaited == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
